// ===== rtl/line_edge_detector_core_defines.svh =====
// Assertion macros for the line edge detector.
`ifndef LINE_EDGE_DETECTOR_CORE_DEFINES_SVH
`define LINE_EDGE_DETECTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LDE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lde: same-cycle check failed");
`define LDE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lde: next-cycle check failed");
`else
`define LDE_ASSERT_IMP(lbl, ante, cons)
`define LDE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/lde_pkg.sv =====
package lde_pkg;

    localparam int PIX_W   = 8;
    localparam int INDEX_W = 12;
    localparam int POS_W   = 11;
    localparam int THR_W   = 8;
    localparam int DIST_W  = 5;
    localparam int ADDR_W  = 4;
    localparam int APB_W   = 32;

    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

    localparam logic [1:0] REG_EDGE_THR = 2'd0;
    localparam logic [1:0] REG_HOLD_THR = 2'd1;
    localparam logic [1:0] REG_DIST     = 2'd2;
    localparam logic [1:0] REG_WIDTH    = 2'd3;

    localparam logic [THR_W-1:0]   RST_EDGE_THR = 8'd20;
    localparam logic [THR_W-1:0]   RST_HOLD_THR = 8'd12;
    localparam logic [DIST_W-1:0]  RST_DIST     = 5'd4;
    localparam logic [INDEX_W-1:0] RST_WIDTH    = 12'd636;

    localparam logic [1:0] SKIP_AFTER_EDGE = 2'd2;

endpackage

// ===== rtl/line_edge_detector_core.sv =====
// Channel   | Direction | Payload
// ----------+-----------+------------------------------------------------------
// s_axis    | in        | tdata[7:0] pixel; tuser[0] line_begin
// m_axis    | out       | tdata[10:0] position; tuser[0] is_line_start, [1] falling
// APB       | in        | 4 registers at 0x0/0x4/0x8/0xC, 32-bit data
//
// One word per cycle sustained while the result is not stalled.
// Stage 1 registers the input word; stage 2 does subtract, compares and the
// mode update and loads the result register.
// A stalled result holds the pipe only while stage 1 is full; a word that
// gives no result never reaches the output.
// Synchronous active-low reset; the four APB registers come up at their defaults.
`include "line_edge_detector_core_defines.svh"

module line_edge_detector_core #(
    parameter int MAX_DISTANCE = 16,
    parameter int MAX_LINE     = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] pixel
    input  logic                          s_axis_tuser,   // [0] line_begin
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [10:0] position, rest zero
    output logic [1:0]                    m_axis_tuser,   // [0] is_line_start, [1] falling
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lde_pkg::ADDR_W-1:0]    paddr,
    input  logic [lde_pkg::APB_W-1:0]     pwdata,
    output logic [lde_pkg::APB_W-1:0]     prdata,
    output logic                          pready
);
    import lde_pkg::*;

    localparam int AW = (MAX_DISTANCE > 1) ? $clog2(MAX_DISTANCE) : 1;
    localparam int LW = INDEX_W + 1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_FALL = 2'd1,
        MODE_RISE = 2'd2
    } t_mode;

    logic [THR_W-1:0]   r_edge_thr;
    logic [THR_W-1:0]   r_hold_thr;
    logic [DIST_W-1:0]  r_dist;
    logic [INDEX_W-1:0] r_width;

    logic               r_in_valid;
    logic [PIX_W-1:0]   r_in_pixel;
    logic               r_in_begin;

    logic [PIX_W-1:0]   r_taps [MAX_DISTANCE];
    t_mode              r_mode;
    logic [1:0]         r_skip;
    logic [INDEX_W-1:0] r_index;

    logic               r_out_valid;
    logic               r_out_start;
    logic               r_out_fall;
    logic [POS_W-1:0]   r_out_pos;

    logic               adv;
    logic               fire;
    logic               cfg_wr;
    logic [INDEX_W-1:0] d_eff;
    logic [LW-1:0]      w_eff;
    logic [INDEX_W-1:0] j;
    logic [AW-1:0]      tap_sel;
    logic signed [9:0]  diff;
    logic signed [9:0]  et_s;
    logic signed [9:0]  ht_s;
    logic               eval;
    logic               report;
    logic               rep_fall;
    t_mode              n_mode;
    logic [1:0]         n_skip;
    logic [INDEX_W-1:0] n_index;
    logic               n_res;
    logic [POS_W-1:0]   n_pos;

    assign adv           = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && adv;
    assign s_axis_tready = !r_in_valid || adv;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign pready        = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_EDGE_THR: prdata = APB_W'(r_edge_thr);
            REG_HOLD_THR: prdata = APB_W'(r_hold_thr);
            REG_DIST:     prdata = APB_W'(r_dist);
            REG_WIDTH:    prdata = APB_W'(r_width);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        if (r_dist == '0) begin
            d_eff = INDEX_W'(1);
        end else if (INDEX_W'(r_dist) > INDEX_W'(MAX_DISTANCE)) begin
            d_eff = INDEX_W'(MAX_DISTANCE);
        end else begin
            d_eff = INDEX_W'(r_dist);
        end
        w_eff   = ({1'b0, r_width} > LW'(MAX_LINE)) ? LW'(MAX_LINE) : {1'b0, r_width};
        j       = r_in_begin ? '0 : r_index;
        tap_sel = AW'(d_eff - INDEX_W'(1));
        diff    = $signed({2'b00, r_in_pixel}) - $signed({2'b00, r_taps[tap_sel]});
        et_s    = $signed({2'b00, r_edge_thr});
        ht_s    = $signed({2'b00, r_hold_thr});
        eval    = !r_in_begin && (j >= d_eff) && ({1'b0, j} < w_eff);
        n_pos   = POS_W'(j - d_eff);
        n_index = (j < INDEX_MAX) ? j + INDEX_W'(1) : INDEX_MAX;

        report   = 1'b0;
        rep_fall = 1'b0;
        n_mode   = r_in_begin ? MODE_IDLE : r_mode;
        n_skip   = r_in_begin ? 2'd0 : r_skip;
        if (eval) begin
            if (r_skip != 2'd0) begin
                n_skip = r_skip - 2'd1;
            end else begin
                case (r_mode)
                    MODE_FALL: begin
                        if (diff > -ht_s) begin
                            n_mode = MODE_IDLE;
                        end else if (diff >= et_s) begin
                            report = 1'b1;
                        end
                    end
                    MODE_RISE: begin
                        if (diff < ht_s) begin
                            n_mode = MODE_IDLE;
                        end else if (diff <= -et_s) begin
                            report   = 1'b1;
                            rep_fall = 1'b1;
                        end
                    end
                    default: begin
                        if (diff <= -et_s) begin
                            report   = 1'b1;
                            rep_fall = 1'b1;
                        end else if (diff >= et_s) begin
                            report = 1'b1;
                        end
                    end
                endcase
            end
        end
        if (report) begin
            n_mode = rep_fall ? MODE_FALL : MODE_RISE;
            n_skip = SKIP_AFTER_EDGE;
        end
        n_res = r_in_begin || report;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_thr  <= RST_EDGE_THR;
            r_hold_thr  <= RST_HOLD_THR;
            r_dist      <= RST_DIST;
            r_width     <= RST_WIDTH;
            r_in_valid  <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_skip      <= 2'd0;
            r_index     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_EDGE_THR: r_edge_thr <= pwdata[THR_W-1:0];
                    REG_HOLD_THR: r_hold_thr <= pwdata[THR_W-1:0];
                    REG_DIST:     r_dist     <= pwdata[DIST_W-1:0];
                    REG_WIDTH:    r_width    <= pwdata[INDEX_W-1:0];
                    default:      r_width    <= r_width;
                endcase
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (fire) begin
                r_mode  <= n_mode;
                r_skip  <= n_skip;
                r_index <= n_index;
            end
            if (adv) begin
                r_out_valid <= r_in_valid && n_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_pixel <= s_axis_tdata;
            r_in_begin <= s_axis_tuser;
        end
        if (fire) begin
            r_taps[0] <= r_in_pixel;
            for (int k = 1; k < MAX_DISTANCE; k++) begin
                r_taps[k] <= r_taps[k-1];
            end
        end
        if (fire && n_res) begin
            r_out_start <= r_in_begin;
            r_out_fall  <= r_in_begin ? 1'b0 : rep_fall;
            r_out_pos   <= r_in_begin ? '0 : n_pos;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 16'(r_out_pos);
    assign m_axis_tuser  = {r_out_fall, r_out_start};

    `LDE_ASSERT_IMP(a_skip_in_edge, r_skip != 2'd0, r_mode == MODE_FALL || r_mode == MODE_RISE)
    `LDE_ASSERT_IMP(a_start_clean, r_out_valid && r_out_start, !r_out_fall && r_out_pos == '0)
    `LDE_ASSERT_IMP(a_ready_stall, !s_axis_tready, r_out_valid && !m_axis_tready && r_in_valid)
    `LDE_ASSERT_NXT(a_begin_token, fire && r_in_begin, r_out_valid && r_out_start)

endmodule
